/* sv/bwb_pkg.sv */
// shared types and constants for the byte write buffer ring
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package bwb_pkg;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int DATA_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 7;

  // parameter defaults
  localparam int DEF_MAX_BUF_BYTES = 64;
  localparam int DEF_NUM_SLOTS     = 8;

  // register reset values
  localparam logic [LEN_W-1:0] BUF_LEN_RESET   = 7'd64;
  localparam logic [CNT_W-1:0] BUF_COUNT_RESET = 4'd8;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BUF_LEN   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BUF_COUNT = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   out_byte;
    logic                out_last;
    logic [LEN_W-1:0]    buffer_length;
    logic [CNT_W-1:0]    free_slots;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic step;       // apply the accepted item to the ring state
    logic rd_en;      // read next drained byte
    logic out_load;   // load the result register
    logic load_byte;  // result comes from the read byte
    logic byte_last;  // final byte of the drain
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drain_start;  // offered item is a drain with a posted slot
    logic rd_last;      // byte now being read is the final one
  } dp_status_t;

endpackage

/* sv/byte_write_buffer_ring.sv */
// top level of the byte write buffer ring
// depends on bwb_pkg, bwb_ctrl and bwb_datapath
`timescale 1ns / 1ps

// A ring of buffer slots, each collecting bytes plus a stored length. A put
// beat writes one byte into the open slot (opening the next free slot first,
// or answering full when none is free); a slot that reaches buf_len bytes is
// posted on its own, and a flush beat posts a partly filled slot with its
// true byte count. A drain beat returns the oldest posted slot as one result
// beat per byte, with out_last on the final one, and frees the slot. Put,
// flush, clear and empty-drain beats can follow in back-to-back cycles
// while results are taken. A drain holds the block: the single registered
// read port of the byte store delivers one byte per cycle while results
// are taken, and the next beat is taken once the final byte sits in the
// result register.
// Writing either configuration register empties the ring, as the clear
// command does; write only while the block is idle. Register values out of
// range are saturated (buf_len to 2..MAX_BUF_BYTES, buf_count to
// 1..NUM_SLOTS). The byte and length stores need no clearing pass after
// reset; only entries written since reset are ever read.

module byte_write_buffer_ring
  import bwb_pkg::*;
#(
  parameter int MAX_BUF_BYTES = DEF_MAX_BUF_BYTES,  // bytes per slot, 2..64
  parameter int NUM_SLOTS     = DEF_NUM_SLOTS       // slots in the ring, 1..15
) (
  input  logic                  clk,
  input  logic                  rst,
  // command beats
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  // result beats
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  // configuration writes
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // handshake and drain sequencing
  bwb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // ring state, stores and result register
  bwb_datapath #(
    .MAX_BUF_BYTES (MAX_BUF_BYTES),
    .NUM_SLOTS     (NUM_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* sv/bwb_ctrl.sv */
// controller state machine for the byte write buffer ring
// depends on bwb_pkg; drives bwb_datapath through ctrl_cmd_t
`timescale 1ns / 1ps

module bwb_ctrl
  import bwb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   q_valid, q_valid_next;
  logic   q_last, q_last_next;
  logic   rd_done, rd_done_next;
  logic   out_free;
  logic   load;
  logic   issue;

  assign out_free     = !out_valid || result_ready;
  assign result_valid = out_valid;

  always_comb begin
    state_next   = state;
    q_valid_next = q_valid;
    q_last_next  = q_last;
    rd_done_next = rd_done;
    item_ready   = 1'b0;
    load         = 1'b0;
    issue        = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        // no beat is taken while reset is held
        item_ready = out_free && !rst;
        if (item_valid && item_ready) begin
          cmd.step = 1'b1;
          if (sts.drain_start) begin
            state_next   = S_DRAIN;
            q_valid_next = 1'b0;
            rd_done_next = 1'b0;
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        load          = q_valid && out_free;
        issue         = !rd_done && (!q_valid || load);
        cmd.rd_en     = issue;
        cmd.out_load  = load;
        cmd.load_byte = 1'b1;
        cmd.byte_last = q_last;
        if (issue) begin
          q_valid_next = 1'b1;
          q_last_next  = sts.rd_last;
          rd_done_next = sts.rd_last;
        end else if (load) begin
          q_valid_next = 1'b0;
        end
        if (load && q_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.out_load ? 1'b1 : (result_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      q_valid   <= 1'b0;
      q_last    <= 1'b0;
      rd_done   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      q_valid   <= q_valid_next;
      q_last    <= q_last_next;
      rd_done   <= rd_done_next;
    end
  end

endmodule

/* sv/bwb_datapath.sv */
// datapath of the byte write buffer ring: registers, ring pointers,
// byte and length memories, result register; depends on bwb_pkg
`timescale 1ns / 1ps

module bwb_datapath
  import bwb_pkg::*;
#(
  parameter int MAX_BUF_BYTES = DEF_MAX_BUF_BYTES,
  parameter int NUM_SLOTS     = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 item,
  output result_t               result,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sts
);

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int BYTE_W  = (MAX_BUF_BYTES > 1) ? $clog2(MAX_BUF_BYTES) : 1;
  localparam int DEPTH   = NUM_SLOTS * MAX_BUF_BYTES;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;

  function automatic logic [CNT_W-1:0] eff_count_f(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > NUM_SLOTS) begin
      r = CNT_W'(NUM_SLOTS);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot_f(input logic [SLOT_W-1:0] s,
                                                     input logic [CNT_W-1:0]  cnt);
    logic [CMP_W-1:0] n;
    n = CMP_W'(s) + CMP_W'(1);
    return (n >= CMP_W'(cnt)) ? '0 : n[SLOT_W-1:0];
  endfunction

  // configuration registers
  logic [LEN_W-1:0] buf_len;
  logic [CNT_W-1:0] buf_count;

  // ring state
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic              slot_open, slot_open_next;
  logic [BYTE_W-1:0] fill_offset, fill_offset_next;

  // drain pointers
  logic [SLOT_W-1:0] drain_slot;
  logic [LEN_W-1:0]  drain_len;
  logic [BYTE_W-1:0] rd_idx;

  // memories
  logic [DATA_W-1:0] byte_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem  [NUM_SLOTS];
  logic [DATA_W-1:0] rd_byte;
  logic [LEN_W-1:0]  len_rd;

  logic [LEN_W-1:0]    eff_len;
  logic [CNT_W-1:0]    eff_count;
  logic [CNT_W-1:0]    cfg_count;
  logic                posted;
  logic [BYTE_W-1:0]   off;
  logic [LEN_W-1:0]    new_len;
  logic [STATUS_W-1:0] step_status;
  logic                mem_we;
  logic                len_we;
  logic [LEN_W-1:0]    len_wdata;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [LEN_W-1:0]    len_clamped;
  logic                step_drain;

  always_comb begin
    eff_len = buf_len;
    if (buf_len < LEN_W'(2)) begin
      eff_len = LEN_W'(2);
    end else if (buf_len > LEN_W'(MAX_BUF_BYTES)) begin
      eff_len = LEN_W'(MAX_BUF_BYTES);
    end
  end

  assign eff_count = eff_count_f(buf_count);
  assign posted    = free_count < eff_count;
  assign off       = slot_open ? fill_offset : '0;
  assign new_len   = LEN_W'(off) + LEN_W'(1);

  assign sts.drain_start = (item.command == CMD_DRAIN) && posted;
  assign sts.rd_last     = (LEN_W'(rd_idx) + LEN_W'(1)) == drain_len;
  assign step_drain      = cmd.step && sts.drain_start;

  // count in force after a configuration write
  assign cfg_count = (cfg_index == REG_BUF_COUNT) ? eff_count_f(cfg_wdata[CNT_W-1:0])
                                                  : eff_count;

  // effect of one item on the ring
  always_comb begin
    write_slot_next  = write_slot;
    read_slot_next   = read_slot;
    free_count_next  = free_count;
    slot_open_next   = slot_open;
    fill_offset_next = fill_offset;
    step_status      = ST_OK;
    mem_we           = 1'b0;
    len_we           = 1'b0;
    len_wdata        = eff_len;
    case (item.command)
      CMD_PUT: begin
        if (!slot_open && free_count == '0) begin
          step_status = ST_FULL;
        end else begin
          mem_we = 1'b1;
          if (new_len >= eff_len) begin
            len_we           = 1'b1;
            len_wdata        = eff_len;
            free_count_next  = free_count - CNT_W'(1);
            write_slot_next  = next_slot_f(write_slot, eff_count);
            slot_open_next   = 1'b0;
            fill_offset_next = '0;
          end else begin
            slot_open_next   = 1'b1;
            fill_offset_next = new_len[BYTE_W-1:0];
          end
        end
      end
      CMD_FLUSH: begin
        if (slot_open && fill_offset != '0) begin
          len_we           = 1'b1;
          len_wdata        = LEN_W'(fill_offset);
          if (free_count != '0) begin
            free_count_next = free_count - CNT_W'(1);
          end
          write_slot_next  = next_slot_f(write_slot, eff_count);
          slot_open_next   = 1'b0;
          fill_offset_next = '0;
        end else begin
          step_status = ST_NONE;
        end
      end
      CMD_DRAIN: begin
        if (posted) begin
          free_count_next = free_count + CNT_W'(1);
          read_slot_next  = next_slot_f(read_slot, eff_count);
        end else begin
          step_status = ST_NONE;
        end
      end
      CMD_CLEAR: begin
        write_slot_next  = '0;
        read_slot_next   = '0;
        free_count_next  = eff_count;
        slot_open_next   = 1'b0;
        fill_offset_next = '0;
      end
      default: begin
        step_status = ST_OK;
      end
    endcase
    if (!cmd.step) begin
      write_slot_next  = write_slot;
      read_slot_next   = read_slot;
      free_count_next  = free_count;
      slot_open_next   = slot_open;
      fill_offset_next = fill_offset;
      mem_we           = 1'b0;
      len_we           = 1'b0;
    end
    if (rst) begin
      write_slot_next  = '0;
      read_slot_next   = '0;
      free_count_next  = eff_count_f(BUF_COUNT_RESET);
      slot_open_next   = 1'b0;
      fill_offset_next = '0;
      mem_we           = 1'b0;
      len_we           = 1'b0;
    end else if (cfg_wen) begin
      write_slot_next  = '0;
      read_slot_next   = '0;
      free_count_next  = cfg_count;
      slot_open_next   = 1'b0;
      fill_offset_next = '0;
      mem_we           = 1'b0;
      len_we           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len   <= BUF_LEN_RESET;
      buf_count <= BUF_COUNT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_BUF_LEN:   buf_len   <= cfg_wdata[LEN_W-1:0];
        REG_BUF_COUNT: buf_count <= cfg_wdata[CNT_W-1:0];
        default:       buf_len   <= buf_len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    write_slot  <= write_slot_next;
    read_slot   <= read_slot_next;
    free_count  <= free_count_next;
    slot_open   <= slot_open_next;
    fill_offset <= fill_offset_next;
  end

  // slot length memory, read kept in step with the read pointer
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[write_slot] <= len_wdata;
    end
    if (len_we && write_slot == read_slot_next) begin
      len_rd <= len_wdata;
    end else begin
      len_rd <= len_mem[read_slot_next];
    end
  end

  always_comb begin
    len_clamped = len_rd;
    if (len_rd > LEN_W'(MAX_BUF_BYTES)) begin
      len_clamped = LEN_W'(MAX_BUF_BYTES);
    end else if (len_rd == '0) begin
      len_clamped = LEN_W'(1);
    end
  end

  // drain pointers
  always_ff @(posedge clk) begin
    if (step_drain) begin
      drain_slot <= read_slot;
      drain_len  <= len_clamped;
      rd_idx     <= '0;
    end else if (cmd.rd_en) begin
      rd_idx <= rd_idx + BYTE_W'(1);
    end
  end

  assign waddr = ADDR_W'(write_slot) * ADDR_W'(MAX_BUF_BYTES) + ADDR_W'(off);
  assign raddr = ADDR_W'(drain_slot) * ADDR_W'(MAX_BUF_BYTES) + ADDR_W'(rd_idx);

  // byte store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[waddr] <= item.data_byte;
    end
    if (cmd.rd_en) begin
      rd_byte <= byte_mem[raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.load_byte) begin
        result.status        <= ST_OK;
        result.out_byte      <= rd_byte;
        result.out_last      <= cmd.byte_last;
        result.buffer_length <= drain_len;
        result.free_slots    <= free_count;
      end else begin
        result.status        <= step_status;
        result.out_byte      <= '0;
        result.out_last      <= 1'b1;
        result.buffer_length <= '0;
        result.free_slots    <= free_count_next;
      end
    end
  end

endmodule

/* verif/tb_byte_write_buffer_ring.sv */
// self-checking testbench for the byte write buffer ring
// depends on bwb_pkg and byte_write_buffer_ring; predicts every result beat in a scoreboard class
`timescale 1ns / 1ps

module tb_byte_write_buffer_ring;
  import bwb_pkg::*;

  localparam int SLOT_BYTES  = DEF_MAX_BUF_BYTES;
  localparam int SLOT_TOTAL  = DEF_NUM_SLOTS;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat in either direction

  // ring predictor plus the queue of result beats still owed by the block
  class ring_scoreboard;
    logic [DATA_W-1:0] byte_mem [SLOT_TOTAL*SLOT_BYTES];
    logic [LEN_W-1:0]  len_mem  [SLOT_TOTAL];
    logic [LEN_W-1:0]  len_reg;
    logic [CNT_W-1:0]  cnt_reg;
    int unsigned       wr_slot, rd_slot, free_cnt, fill;
    bit                slot_open;
    result_t           owed_q[$];
    int unsigned       fails, n_in, n_out, n_full, n_drains, n_writes;

    function new();
      len_reg = BUF_LEN_RESET;
      cnt_reg = BUF_COUNT_RESET;
      clear_ring();
    endfunction

    // register values as the block uses them, saturated
    function int unsigned span();
      if (len_reg < 2) return 2;
      if (len_reg > SLOT_BYTES) return SLOT_BYTES;
      return 32'(len_reg);
    endfunction

    function int unsigned ring_size();
      if (cnt_reg < 1) return 1;
      if (cnt_reg > SLOT_TOTAL) return SLOT_TOTAL;
      return 32'(cnt_reg);
    endfunction

    function void clear_ring();
      wr_slot   = 0;
      rd_slot   = 0;
      free_cnt  = ring_size();
      slot_open = 0;
      fill      = 0;
    endfunction

    function int unsigned slot_after(int unsigned s);
      return (s + 1 >= ring_size()) ? 0 : s + 1;
    endfunction

    function void post(int unsigned n);
      len_mem[wr_slot] = n[LEN_W-1:0];
      if (free_cnt > 0) free_cnt--;
      wr_slot   = slot_after(wr_slot);
      slot_open = 0;
      fill      = 0;
    endfunction

    function void owe(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] b, logic last,
                      int unsigned n);
      result_t r;
      r.status        = st;
      r.out_byte      = b;
      r.out_last      = last;
      r.buffer_length = n[LEN_W-1:0];
      r.free_slots    = free_cnt[CNT_W-1:0];
      owed_q.push_back(r);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      if (idx == REG_BUF_LEN) len_reg = v[LEN_W-1:0];
      else cnt_reg = v[CNT_W-1:0];
      clear_ring();
      n_writes++;
    endfunction

    // works out the result beats of one accepted command beat
    function void note_item(item_t it);
      int unsigned slot, n;
      n_in++;
      case (it.command)
        CMD_PUT: begin
          if (!slot_open && free_cnt == 0) begin
            owe(ST_FULL, '0, 1'b1, 0);
            n_full++;
          end else begin
            if (!slot_open) begin
              slot_open = 1;
              fill      = 0;
            end
            byte_mem[wr_slot*SLOT_BYTES + fill] = it.data_byte;
            fill++;
            if (fill >= span()) post(span());
            owe(ST_OK, '0, 1'b1, 0);
          end
        end
        CMD_FLUSH: begin
          if (slot_open && fill > 0) begin
            post(fill);
            owe(ST_OK, '0, 1'b1, 0);
          end else begin
            owe(ST_NONE, '0, 1'b1, 0);
          end
        end
        CMD_DRAIN: begin
          if (free_cnt >= ring_size()) begin
            owe(ST_NONE, '0, 1'b1, 0);
          end else begin
            slot = rd_slot;
            n    = 32'(len_mem[slot]);
            if (n > SLOT_BYTES) n = SLOT_BYTES;
            if (n == 0) n = 1;
            free_cnt++;
            rd_slot = slot_after(rd_slot);
            for (int unsigned i = 0; i < n; i++)
              owe(ST_OK, byte_mem[slot*SLOT_BYTES + i], (i + 1 == n), n);
            n_drains++;
          end
        end
        default: begin
          clear_ring();
          owe(ST_OK, '0, 1'b1, 0);
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        fails++;
        return;
      end
      want = owed_q.pop_front();
      n_out++;
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      cmp_field("out_last", 32'(want.out_last), 32'(got.out_last));
      cmp_field("buffer_length", 32'(want.buffer_length), 32'(got.buffer_length));
      cmp_field("free_slots", 32'(want.free_slots), 32'(got.free_slots));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready;
  result_t               result;
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ring_scoreboard sb;

  // sender burst state and receiver stall state
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_cycle   = 0;
  int unsigned idle_cycles = 0;

  always #6 clk = ~clk;

  byte_write_buffer_ring dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // receiver: three stall styles, switched by a free-running cycle counter
  // mode 0 always ready, mode 1 coin flip, mode 2 mostly ready with long stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(5, 40);
            result_ready <= 1'b0;
          end else begin
            result_ready <= 1'b1;
          end
        end
      endcase
    end
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
  end

  // every accepted result beat is checked against the oldest owed beat
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // watchdog: a run that stops moving beats is a failure
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one command beat; a new burst starts with a random gap
  // valid stays high between beats of the same burst
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data);
    item_t       it;
    int unsigned gap;
    it.command   = cmd;
    it.data_byte = data;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
    burst_left--;
  endtask

  // let every owed beat come back, then idle for a margin
  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register writes only when the block is idle; each one empties the ring
  task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    settle();
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.write_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  // well-formed use: a run of puts, usually a flush, then a drain
  task automatic send_packet();
    int unsigned n, cap;
    cap = (sb.span() < 12) ? sb.span() : 12;
    n   = ($urandom_range(0, 7) == 0) ? sb.span() : $urandom_range(1, cap);
    repeat (n) send(CMD_PUT, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) send(CMD_FLUSH, 8'($urandom_range(0, 255)));
    send(CMD_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  // one random phase under a given register setting
  // put_pct shifts the mix between filling the ring up and draining it dry
  task automatic run_phase(input int unsigned len_val, input int unsigned cnt_val,
                           input int unsigned beats);
    int unsigned stop, put_pct, r;
    logic [CMD_W-1:0] cmd;
    set_reg(REG_BUF_LEN, len_val);
    set_reg(REG_BUF_COUNT, cnt_val);
    put_pct = $urandom_range(35, 85);
    stop    = sb.n_in + beats;
    while (sb.n_in < stop) begin
      if ($urandom_range(0, 3) == 0) begin
        send_packet();
      end else begin
        r = $urandom_range(0, 99);
        if (r < put_pct) cmd = CMD_PUT;
        else if (r >= 97) cmd = CMD_CLEAR;
        else if (r < put_pct + (97 - put_pct) / 3) cmd = CMD_FLUSH;
        else cmd = CMD_DRAIN;
        send(cmd, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    cfg_wen      = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    sb           = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values: empty drain, empty flush, short packet
    send(CMD_DRAIN, 8'h00);
    send(CMD_FLUSH, 8'hFF);
    send(CMD_PUT, 8'h00);
    send(CMD_PUT, 8'hFF);
    send(CMD_FLUSH, 8'h00);
    send(CMD_DRAIN, 8'h00);

    // one slot of two bytes: full refusal, flush of a partial slot, auto post
    set_reg(REG_BUF_LEN, 2);
    set_reg(REG_BUF_COUNT, 1);
    send(CMD_PUT, 8'h80);
    send(CMD_FLUSH, 8'h00);
    send(CMD_PUT, 8'h7F);     // ring full, byte dropped
    send(CMD_DRAIN, 8'h00);
    send(CMD_PUT, 8'h01);
    send(CMD_PUT, 8'h02);     // slot posted at buf_len
    send(CMD_PUT, 8'h03);     // full again
    send(CMD_DRAIN, 8'h00);

    // two slots: drain next to an open slot, clear command
    set_reg(REG_BUF_COUNT, 2);
    send(CMD_PUT, 8'h11);
    send(CMD_PUT, 8'h22);
    send(CMD_PUT, 8'h33);     // opens the second slot
    send(CMD_DRAIN, 8'h00);   // only the posted slot comes out
    send(CMD_FLUSH, 8'h00);
    send(CMD_DRAIN, 8'h00);
    send(CMD_PUT, 8'h44);
    send(CMD_CLEAR, 8'hA5);
    send(CMD_DRAIN, 8'h00);
    send(CMD_FLUSH, 8'h00);

    // random phases; out of range values check saturation at both ends
    run_phase(64, 8, 45);
    run_phase(0, 0, 30);
    run_phase(127, 15, 35);
    run_phase(5, 3, 40);
    run_phase(2, 8, 45);
    run_phase(64, 1, 35);
    run_phase(9, 4, 40);
    run_phase($urandom_range(2, 64), $urandom_range(1, 8), 45);

    settle();
    repeat (8) @(posedge clk);

    $display("covered %0d command beats, %0d result beats, %0d slot drains, %0d full refusals",
             sb.n_in, sb.n_out, sb.n_drains, sb.n_full);
    $display("over %0d register writes, slot sizes 2 to 64 and ring sizes 1 to 8",
             sb.n_writes);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
